>>> hw/rtl/yuvls_pkg.sv
// shared types and constants for the yuv 4:2:2 line rescaler
// field widths, register and operation codes, controller states, divider request/response
// no dependencies
package yuvls_pkg;

    localparam int DEF_SOURCE_WIDTH = 720;
    localparam int SCALE_SPAN       = 720;

    localparam int COL_W     = 10;
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 11;
    localparam int POS_W     = 20;
    localparam int PROD_W    = PIX_W + WIDTH_W;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [WIDTH_W-1:0] OUT_WIDTH_RESET = 11'd720;

    // bit-serial divider sizing
    localparam int DIV_NUM_W = 21;
    localparam int DIV_DEN_W = 12;
    localparam int DIV_CNT_W = 5;
    localparam int BLEND_Q_W = 8;
    localparam logic [DIV_CNT_W-1:0] DIV_POS_STEPS   = 5'd21;
    localparam logic [DIV_CNT_W-1:0] DIV_BLEND_STEPS = 5'd8;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PRODUCE = 1'b1
    } t_op;

    typedef enum logic {
        REG_SCALE_ENABLE = 1'b0,
        REG_OUTPUT_WIDTH = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_COPY_RD,
        ST_COPY_CAP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RD_Y,
        ST_RD_C,
        ST_CAP_C,
        ST_MUL,
        ST_SUM,
        ST_BLEND_GO,
        ST_BLEND_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_DEN_W-1:0] rem;
        logic [DIV_NUM_W-1:0] dvd;
        logic [DIV_DEN_W-1:0] den;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
        logic [DIV_DEN_W-1:0] rem;
    } t_div_rsp;

endpackage

>>> hw/rtl/yuvls_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no package dependencies
module yuvls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 720
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/yuvls_div.sv
// restoring radix-2 divider, one quotient bit per cycle, preloadable remainder
// depends on yuvls_pkg for widths and the request/response structs
module yuvls_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  yuvls_pkg::t_div_req i_req,
    output yuvls_pkg::t_div_rsp o_rsp
);
    import yuvls_pkg::*;

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_NUM_W-1:0] n_q;

    always_comb begin
        trial = {r_rem, r_q[DIV_NUM_W-1]};
        ge    = (trial >= {1'b0, r_den});
        diff  = trial - {1'b0, r_den};
        n_rem = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        n_q   = {r_q[DIV_NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_q   <= i_req.dvd;
            r_den <= i_req.den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;
    assign o_rsp.rem  = r_rem;

endmodule

>>> hw/rtl/yuv422_line_linear_rescaler_unit.sv
// horizontal linear rescaler for one line of yuv 4:2:2
// a load writes the line store; out-of-range goes straight to output; copy reads the store;
// scaled runs two bit-serial divider passes (positions, then blends); one word at a time
// a produce waits in its output state while the output register is full; a new word is
// taken while a finished result still waits there
// sync active-low reset clears controller, config (scale off, width 720), output valid and divider counters only
module yuv422_line_linear_rescaler_unit #(
    parameter int SOURCE_WIDTH = yuvls_pkg::DEF_SOURCE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [9:0] column, [17:10] luma_in, [25:18] chroma_in, [31:26] zero
    input  logic [yuvls_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] operation
    input  logic                                i_s_axis_tuser,
    // master side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] luma_out, [15:8] chroma_out
    output logic [yuvls_pkg::M_TDATA_W-1:0]     o_m_axis_tdata,
    // [0] out_of_range
    output logic                                o_m_axis_tuser,
    // config write port
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_addr,
    input  logic [yuvls_pkg::WIDTH_W-1:0]       i_cfg_wr_data
);
    import yuvls_pkg::*;

    localparam int AW    = (SOURCE_WIDTH > 1) ? $clog2(SOURCE_WIDTH) : 1;
    localparam int IDX_W = DIV_NUM_W;
    localparam logic [IDX_W-1:0]   LAST_COL  = IDX_W'(SOURCE_WIDTH - 1);
    localparam logic [IDX_W-1:0]   LAST_PAIR = IDX_W'(SOURCE_WIDTH / 2 - 1);
    localparam logic [WIDTH_W:0]   SW_L      = (WIDTH_W + 1)'(SOURCE_WIDTH);

    // ------------------------------------------------------------------
    // input word unpack
    // ------------------------------------------------------------------
    logic [COL_W-1:0] in_col;
    logic [PIX_W-1:0] in_luma;
    logic [PIX_W-1:0] in_chroma;
    t_op              in_op;
    logic             accept;
    logic             in_beyond_line;
    logic             in_beyond_width;
    logic             in_oor;

    assign in_col    = i_s_axis_tdata[COL_W-1:0];
    assign in_luma   = i_s_axis_tdata[COL_W+PIX_W-1:COL_W];
    assign in_chroma = i_s_axis_tdata[COL_W+2*PIX_W-1:COL_W+PIX_W];
    assign in_op     = t_op'(i_s_axis_tuser);
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state              r_state;
    t_state              n_state;
    logic                r_scale_en;
    logic [WIDTH_W-1:0]  r_out_width;

    logic [COL_W-1:0]    r_col;
    logic [2*PIX_W-1:0]  r_wdata;
    logic [WIDTH_W-1:0]  r_yf;
    logic [WIDTH_W-1:0]  r_cf;
    logic [PIX_W-1:0]    r_ya;
    logic [PIX_W-1:0]    r_yb;
    logic [PIX_W-1:0]    r_ca;
    logic [PIX_W-1:0]    r_cb;
    logic [PROD_W-1:0]   r_pya;
    logic [PROD_W-1:0]   r_pyb;
    logic [PROD_W-1:0]   r_pca;
    logic [PROD_W-1:0]   r_pcb;
    logic [DIV_NUM_W-1:0] r_dvd_y;
    logic [DIV_NUM_W-1:0] r_dvd_c;
    logic [PIX_W-1:0]    r_res_luma;
    logic [PIX_W-1:0]    r_res_chroma;
    logic                r_res_oor;

    // output register
    logic                r_m_valid;
    logic [PIX_W-1:0]    r_m_luma;
    logic [PIX_W-1:0]    r_m_chroma;
    logic                r_m_oor;
    logic                out_free;

    // column beyond the line store or beyond the output width
    assign in_beyond_line  = ((WIDTH_W + 1)'(in_col) >= SW_L);
    assign in_beyond_width = (WIDTH_W'(in_col) >= r_out_width);
    assign in_oor          = in_beyond_width || (!r_scale_en && in_beyond_line);
    assign out_free        = !r_m_valid || i_m_axis_tready;

    // ------------------------------------------------------------------
    // line store: two identical banks, so both neighbours are read in the same cycle
    // entry layout: luma in the high byte, chroma in the low byte
    // ------------------------------------------------------------------
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       raddr_a;
    logic [AW-1:0]       raddr_b;
    logic [2*PIX_W-1:0]  rd_a;
    logic [2*PIX_W-1:0]  rd_b;

    yuvls_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (SOURCE_WIDTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_wdata),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    yuvls_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (SOURCE_WIDTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_wdata),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    // ------------------------------------------------------------------
    // dividers: luma lane and chroma lane run in lockstep
    // first pass gives source position and fraction, second pass the rounded blend
    // ------------------------------------------------------------------
    t_div_req div_req_y;
    t_div_req div_req_c;
    t_div_rsp div_rsp_y;
    t_div_rsp div_rsp_c;

    yuvls_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req_y),
        .o_rsp   (div_rsp_y)
    );

    yuvls_div u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req_c),
        .o_rsp   (div_rsp_c)
    );

    // scaled positions: col*720 and (col>>1)*720
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_c;

    assign pos_y = POS_W'(r_col) * POS_W'(SCALE_SPAN);
    assign pos_c = POS_W'(r_col >> 1) * POS_W'(SCALE_SPAN);

    // neighbour indexes, right neighbour and short-line left neighbour saturate
    logic [IDX_W-1:0] col_ext;
    logic [IDX_W-1:0] yl;
    logic [IDX_W-1:0] yr;
    logic [IDX_W-1:0] cl;
    logic [IDX_W-1:0] cr;
    logic [IDX_W-1:0] il;
    logic [IDX_W-1:0] ir;
    logic             y_sat;
    logic             c_sat;

    always_comb begin
        col_ext = IDX_W'(r_col);
        y_sat   = (div_rsp_y.quo >= LAST_COL);
        yl      = y_sat ? LAST_COL : div_rsp_y.quo;
        yr      = y_sat ? LAST_COL : div_rsp_y.quo + IDX_W'(1);
        c_sat   = (div_rsp_c.quo >= LAST_PAIR);
        cl      = c_sat ? LAST_PAIR : div_rsp_c.quo;
        cr      = c_sat ? LAST_PAIR : div_rsp_c.quo + IDX_W'(1);
        // pair index to column, keeping the u/v phase of the output column
        il      = {cl[IDX_W-2:0], r_col[0]};
        ir      = {cr[IDX_W-2:0], r_col[0]};
    end

    // blend weights and dividends: 2*(a*(w-f) + b*f) + w over 2*w
    logic [WIDTH_W-1:0] w_minus_yf;
    logic [WIDTH_W-1:0] w_minus_cf;
    logic [PROD_W:0]    acc_y;
    logic [PROD_W:0]    acc_c;

    assign w_minus_yf = r_out_width - r_yf;
    assign w_minus_cf = r_out_width - r_cf;
    assign acc_y      = (PROD_W + 1)'(r_pya) + (PROD_W + 1)'(r_pyb);
    assign acc_c      = (PROD_W + 1)'(r_pca) + (PROD_W + 1)'(r_pcb);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == OP_LOAD) begin
                        // loads past the line end are dropped
                        n_state = in_beyond_line ? ST_IDLE : ST_WRITE;
                    end else if (in_oor) begin
                        n_state = ST_OUT;
                    end else if (!r_scale_en) begin
                        n_state = ST_COPY_RD;
                    end else begin
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_WRITE:      n_state = ST_IDLE;
            ST_COPY_RD:    n_state = ST_COPY_CAP;
            ST_COPY_CAP:   n_state = ST_OUT;
            ST_DIV_GO:     n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_rsp_y.done) begin
                    n_state = ST_RD_Y;
                end
            end
            ST_RD_Y:       n_state = ST_RD_C;
            ST_RD_C:       n_state = ST_CAP_C;
            ST_CAP_C:      n_state = ST_MUL;
            ST_MUL:        n_state = ST_SUM;
            ST_SUM:        n_state = ST_BLEND_GO;
            ST_BLEND_GO:   n_state = ST_BLEND_WAIT;
            ST_BLEND_WAIT: begin
                if (div_rsp_y.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait here while the output register holds an untaken word
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:       n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // controller outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        ram_we          = (r_state == ST_WRITE);
        ram_waddr       = col_ext[AW-1:0];
        raddr_a         = col_ext[AW-1:0];
        raddr_b         = col_ext[AW-1:0];

        // position pass by default, start only in the go states
        div_req_y.start = 1'b0;
        div_req_y.rem   = '0;
        div_req_y.dvd   = IDX_W'(pos_y);
        div_req_y.den   = DIV_DEN_W'(r_out_width);
        div_req_y.steps = DIV_POS_STEPS;
        div_req_c.start = 1'b0;
        div_req_c.rem   = '0;
        div_req_c.dvd   = IDX_W'(pos_c);
        div_req_c.den   = DIV_DEN_W'(r_out_width);
        div_req_c.steps = DIV_POS_STEPS;

        case (r_state)
            ST_DIV_GO: begin
                div_req_y.start = 1'b1;
                div_req_c.start = 1'b1;
            end
            ST_RD_Y: begin
                raddr_a = yl[AW-1:0];
                raddr_b = yr[AW-1:0];
            end
            ST_RD_C: begin
                raddr_a = il[AW-1:0];
                raddr_b = ir[AW-1:0];
            end
            ST_BLEND_GO: begin
                // quotient fits 8 bits, so the top of the dividend preloads the remainder
                div_req_y.start = 1'b1;
                div_req_y.rem   = r_dvd_y[DIV_DEN_W+BLEND_Q_W-1:BLEND_Q_W];
                div_req_y.dvd   = {r_dvd_y[BLEND_Q_W-1:0], (DIV_NUM_W - BLEND_Q_W)'(0)};
                div_req_y.den   = {r_out_width, 1'b0};
                div_req_y.steps = DIV_BLEND_STEPS;
                div_req_c.start = 1'b1;
                div_req_c.rem   = r_dvd_c[DIV_DEN_W+BLEND_Q_W-1:BLEND_Q_W];
                div_req_c.dvd   = {r_dvd_c[BLEND_Q_W-1:0], (DIV_NUM_W - BLEND_Q_W)'(0)};
                div_req_c.den   = {r_out_width, 1'b0};
                div_req_c.steps = DIV_BLEND_STEPS;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scale_en  <= 1'b0;
            r_out_width <= OUT_WIDTH_RESET;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_SCALE_ENABLE: r_scale_en  <= i_cfg_wr_data[0];
                    REG_OUTPUT_WIDTH: r_out_width <= i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_OUT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_col        <= in_col;
            r_wdata      <= {in_luma, in_chroma};
            r_res_oor    <= in_oor;
            r_res_luma   <= '0;
            r_res_chroma <= '0;
        end
        case (r_state)
            ST_COPY_CAP: begin
                r_res_luma   <= rd_a[2*PIX_W-1:PIX_W];
                r_res_chroma <= rd_a[PIX_W-1:0];
            end
            ST_RD_Y: begin
                r_yf <= div_rsp_y.rem[WIDTH_W-1:0];
                r_cf <= div_rsp_c.rem[WIDTH_W-1:0];
            end
            ST_RD_C: begin
                r_ya <= rd_a[2*PIX_W-1:PIX_W];
                r_yb <= rd_b[2*PIX_W-1:PIX_W];
            end
            ST_CAP_C: begin
                r_ca <= rd_a[PIX_W-1:0];
                r_cb <= rd_b[PIX_W-1:0];
            end
            ST_MUL: begin
                r_pya <= PROD_W'(r_ya) * PROD_W'(w_minus_yf);
                r_pyb <= PROD_W'(r_yb) * PROD_W'(r_yf);
                r_pca <= PROD_W'(r_ca) * PROD_W'(w_minus_cf);
                r_pcb <= PROD_W'(r_cb) * PROD_W'(r_cf);
            end
            ST_SUM: begin
                r_dvd_y <= DIV_NUM_W'({acc_y, 1'b0}) + DIV_NUM_W'(r_out_width);
                r_dvd_c <= DIV_NUM_W'({acc_c, 1'b0}) + DIV_NUM_W'(r_out_width);
            end
            ST_BLEND_WAIT: begin
                if (div_rsp_y.done) begin
                    r_res_luma   <= div_rsp_y.quo[BLEND_Q_W-1:0];
                    r_res_chroma <= div_rsp_c.quo[BLEND_Q_W-1:0];
                end
            end
            default: begin
            end
        endcase
        if (r_state == ST_OUT && out_free) begin
            r_m_luma   <= r_res_luma;
            r_m_chroma <= r_res_chroma;
            r_m_oor    <= r_res_oor;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_chroma, r_m_luma};
    assign o_m_axis_tuser  = r_m_oor;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp_y.done == div_rsp_c.done)
        else $error("divider lanes out of step");

    a_out_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_m_valid && !i_m_axis_tready)
        |=> (r_state == ST_OUT && r_m_valid))
        else $error("result overwrote an untaken output word");

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("out-of-range word with nonzero pixel");

endmodule

>>> tb/sv/yuvls_pixel_checker.sv
// pixel checker for the yuv 4:2:2 line rescaler: watches the load/produce and result streams,
// keeps its own line store and register copy, and compares every result word field by field
// depends on yuvls_pkg
module yuvls_pixel_checker #(
    parameter int SRC_W = yuvls_pkg::DEF_SOURCE_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // [9:0] column, [17:10] luma_in, [25:18] chroma_in, [31:26] zero
    input  logic [yuvls_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [0] operation
    input  logic                                i_s_tuser,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] luma_out, [15:8] chroma_out
    input  logic [yuvls_pkg::M_TDATA_W-1:0]     i_m_tdata,
    // [0] out_of_range
    input  logic                                i_m_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic                                i_cfg_addr,
    input  logic [yuvls_pkg::WIDTH_W-1:0]       i_cfg_wr_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import yuvls_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma;
    } t_src_px;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma;
        logic             oor;
    } t_out_px;

    t_src_px              line_px [SRC_W];
    logic                 scale_on;
    logic [WIDTH_W-1:0]   out_width;
    t_out_px              expected_pixels [$];
    int                   fails = 0;

    assign o_fail_count = fails;

    function automatic int unsigned sat_index(input int unsigned v, input int unsigned lim);
        return (v >= lim) ? lim - 1 : v;
    endfunction

    // a*(1-f) + b*f with f = num/w, rounded half up
    function automatic logic [PIX_W-1:0] blend_px(input int unsigned a, input int unsigned b,
                                                  input int unsigned num, input int unsigned w);
        int unsigned acc;
        acc = a * (w - num) + b * num;
        return PIX_W'((2 * acc + w) / (2 * w));
    endfunction

    function automatic t_out_px interpolate_pixel(input logic [COL_W-1:0] column);
        t_out_px     px;
        int unsigned col;
        int unsigned w;
        int unsigned pairs;
        int unsigned py;
        int unsigned y_lo;
        int unsigned pc;
        int unsigned c_lo;
        int unsigned c_left;
        int unsigned c_right;
        px    = '0;
        col   = column;
        w     = out_width;
        pairs = (SRC_W / 2 == 0) ? 1 : SRC_W / 2;
        if (col >= w || (!scale_on && col >= SRC_W)) begin
            px.oor = 1'b1;
        end else if (!scale_on) begin
            px.luma   = line_px[col].luma;
            px.chroma = line_px[col].chroma;
        end else begin
            py        = col * SCALE_SPAN;
            y_lo      = py / w;
            px.luma   = blend_px(line_px[sat_index(y_lo, SRC_W)].luma,
                                 line_px[sat_index(y_lo + 1, SRC_W)].luma, py % w, w);
            // chroma works on pairs, keeping the u/v phase of the output column
            pc        = (col >> 1) * SCALE_SPAN;
            c_lo      = pc / w;
            c_left    = sat_index(sat_index(c_lo, pairs) * 2 + col[0], SRC_W);
            c_right   = sat_index(sat_index(c_lo + 1, pairs) * 2 + col[0], SRC_W);
            px.chroma = blend_px(line_px[c_left].chroma, line_px[c_right].chroma, pc % w, w);
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_out_px          want;
        t_out_px          got;
        logic [COL_W-1:0] col;
        if (!i_rst_n) begin
            scale_on  = 1'b0;
            out_width = OUT_WIDTH_RESET;
            expected_pixels.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_SCALE_ENABLE: scale_on  = i_cfg_wr_data[0];
                    REG_OUTPUT_WIDTH: out_width = i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                col = i_s_tdata[COL_W-1:0];
                if (t_op'(i_s_tuser) == OP_LOAD) begin
                    if (col < SRC_W) begin
                        line_px[col].luma   = i_s_tdata[COL_W +: PIX_W];
                        line_px[col].chroma = i_s_tdata[COL_W + PIX_W +: PIX_W];
                    end
                end else begin
                    expected_pixels.push_back(interpolate_pixel(col));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.luma   = i_m_tdata[PIX_W-1:0];
                got.chroma = i_m_tdata[2*PIX_W-1:PIX_W];
                got.oor    = i_m_tuser;
                if (expected_pixels.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word luma %h chroma %h oor %b",
                             $time, got.luma, got.chroma, got.oor);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.luma !== want.luma) begin
                        fails++;
                        $display("%0t: luma_out expected %h actual %h",
                                 $time, want.luma, got.luma);
                    end
                    if (got.chroma !== want.chroma) begin
                        fails++;
                        $display("%0t: chroma_out expected %h actual %h",
                                 $time, want.chroma, got.chroma);
                    end
                    if (got.oor !== want.oor) begin
                        fails++;
                        $display("%0t: out_of_range expected %b actual %b",
                                 $time, want.oor, got.oor);
                    end
                end
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

>>> tb/sv/tb.sv
// top of the yuv 4:2:2 line rescaler testbench: clock, reset, load/produce stimulus,
// result-side stalls and the verdict; checking lives in yuvls_pixel_checker
// depends on yuvls_pkg, yuvls_pixel_checker and yuv422_line_linear_rescaler_unit
module tb;
    import yuvls_pkg::*;

    // cycles to wait once nothing is expected: a load may still be writing the store
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;

    logic                   s_tvalid      = 1'b0;
    logic                   s_tready;
    // [9:0] column, [17:10] luma_in, [25:18] chroma_in, [31:26] zero
    logic [S_TDATA_W-1:0]   s_tdata       = '0;
    // [0] operation
    logic                   s_tuser       = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready      = 1'b0;
    // [7:0] luma_out, [15:8] chroma_out
    logic [M_TDATA_W-1:0]   m_tdata;
    // [0] out_of_range
    logic                   m_tuser;
    logic                   cfg_wr_en     = 1'b0;
    logic                   cfg_addr      = 1'b0;
    logic [WIDTH_W-1:0]     cfg_wr_data   = '0;

    int                     fail_count;
    int                     pending;

    // sender burst state
    int unsigned            burst_left    = 0;

    // receiver stall pattern, plus one long hold-off on request
    logic                   hold_req      = 1'b0;
    logic                   hold_taken    = 1'b0;
    int unsigned            hold_cnt      = 0;
    int unsigned            run_cnt       = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    yuv422_line_linear_rescaler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    yuvls_pixel_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wr_data (cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // result side: runs of ready, runs of stall, and choppy stretches;
    // the long hold-off fires once when asked and keeps ready low regardless
    always @(posedge i_clk) begin
        if (hold_cnt != 0) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cnt   <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (run_cnt != 0) begin
            run_cnt <= run_cnt - 1;
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    m_tready <= 1'b1;
                    run_cnt  <= $urandom_range(20, 60);
                end
                1: begin
                    m_tready <= 1'b0;
                    run_cnt  <= $urandom_range(1, 15);
                end
                default: begin
                    m_tready <= 1'($urandom_range(0, 1));
                    run_cnt  <= $urandom_range(0, 4);
                end
            endcase
        end
    end

    // offer one word and hold it until taken; a random gap opens each new burst,
    // and some gaps are zero so bursts run back to back
    task automatic send_word(input t_op op, input logic [COL_W-1:0] col,
                             input logic [PIX_W-1:0] luma, input logic [PIX_W-1:0] chroma);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end else begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, chroma, luma, col};
        s_tuser  <= op;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // stop offering until every expected result has come back, then let the block settle
    task automatic wait_line_idle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called while the block is idle
    task automatic set_mode(input logic scale, input int unsigned width);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_SCALE_ENABLE;
        cfg_wr_data <= WIDTH_W'(scale);
        @(posedge i_clk);
        cfg_addr    <= REG_OUTPUT_WIDTH;
        cfg_wr_data <= WIDTH_W'(width);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // random mix of loads and produces under one mode; produces mostly hit legal columns,
    // the rest land anywhere and may come back out of range
    task automatic run_phase(input logic scale, input int unsigned width, input int n_words,
                             input logic with_hold);
        int unsigned lim;
        int unsigned col;
        wait_line_idle();
        set_mode(scale, width);
        if (with_hold)
            hold_req <= 1'b1;
        lim = (!scale && width > DEF_SOURCE_WIDTH) ? DEF_SOURCE_WIDTH : width;
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 19) == 0)
                    col = $urandom_range(DEF_SOURCE_WIDTH, 1023);
                else
                    col = $urandom_range(0, DEF_SOURCE_WIDTH - 1);
                send_word(OP_LOAD, COL_W'(col), PIX_W'($urandom), PIX_W'($urandom));
            end else begin
                if ($urandom_range(0, 9) != 0)
                    col = $urandom_range(0, lim - 1);
                else
                    col = $urandom_range(0, 1023);
                send_word(OP_PRODUCE, COL_W'(col), PIX_W'($urandom), PIX_W'($urandom));
            end
            // now and then drain completely in the middle of a phase
            if ($urandom_range(0, 199) == 0)
                wait_line_idle();
        end
    endtask

    initial begin
        logic rev;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: copy mode at reset settings, extreme bytes at both ends of the line
        send_word(OP_LOAD, 10'd0,   8'h00, 8'hff);
        send_word(OP_LOAD, 10'd1,   8'hff, 8'h00);
        send_word(OP_LOAD, 10'd2,   8'haa, 8'h55);
        send_word(OP_LOAD, 10'd3,   8'h55, 8'haa);
        send_word(OP_LOAD, 10'd718, 8'h01, 8'h80);
        send_word(OP_LOAD, 10'd719, 8'hfe, 8'h7f);
        // loads past the end of the line are dropped
        send_word(OP_LOAD, 10'd720,  8'h12, 8'h34);
        send_word(OP_LOAD, 10'd1023, 8'hff, 8'hff);
        send_word(OP_PRODUCE, 10'd0,    8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd1,    8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd718,  8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd719,  8'h00, 8'h00);
        // column beyond width and beyond the line
        send_word(OP_PRODUCE, 10'd720,  8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd1023, 8'hff, 8'hff);

        // directed: scale mode at 720, right neighbor clamps at the line end
        wait_line_idle();
        set_mode(1'b1, 720);
        send_word(OP_PRODUCE, 10'd0,   8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd1,   8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd718, 8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd719, 8'h00, 8'h00);
        send_word(OP_PRODUCE, 10'd720, 8'h00, 8'h00);

        // fill the whole line so every later read hits a written entry
        rev = 1'($urandom_range(0, 1));
        for (int i = 0; i < DEF_SOURCE_WIDTH; i++)
            send_word(OP_LOAD, COL_W'(rev ? DEF_SOURCE_WIDTH - 1 - i : i),
                      PIX_W'($urandom), PIX_W'($urandom));

        // random phases over several settings, the width extremes among them
        run_phase(1'b1, 2,    100, 1'b0);
        run_phase(1'b1, 1024, 150, 1'b0);
        // copy mode is fast, so the long hold-off backs the block up into its input
        run_phase(1'b0, 1024, 150, 1'b1);
        run_phase(1'b0, 640,  120, 1'b0);
        run_phase(1'b1, 768,  150, 1'b0);
        run_phase(1'b1, 640,  150, 1'b0);
        run_phase(1'b0, 2,     60, 1'b0);
        run_phase(1'b1, $urandom_range(2, 1024), 140, 1'b0);
        run_phase(1'b1, $urandom_range(2, 1024), 140, 1'b0);

        wait_line_idle();
        if (fail_count == 0)
            $display("PASS yuv422_line_linear_rescaler_unit");
        else
            $display("FAIL yuv422_line_linear_rescaler_unit");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #1500000;
        $display("FAIL yuv422_line_linear_rescaler_unit");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/yuvls_pkg.sv
hw/rtl/yuvls_ram.sv
hw/rtl/yuvls_div.sv
hw/rtl/yuv422_line_linear_rescaler_unit.sv
tb/sv/yuvls_pixel_checker.sv
tb/sv/tb.sv
